>>> design/uvs_pkg.sv
// uvs_pkg: constants, types and arithmetic helpers for the uv sphere vertex generator
// no dependencies; used by every other file of the block
package uvs_pkg;

  localparam int unsigned CNT_W         = 11;
  localparam int unsigned IDX_W         = 11;
  localparam int unsigned RAD_W         = 16;
  localparam int unsigned FRAC_W        = 17;
  localparam int unsigned POS_W         = 17;
  localparam int unsigned NRM_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned NUM_W         = 27;
  localparam int unsigned PHASE_W       = 16;
  localparam int unsigned Q30_W         = 30;

  localparam logic [CNT_W-1:0] MAX_DIVISIONS = 11'd1024;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0] SLICES_RST = 11'd32;
  localparam logic [CNT_W-1:0] STACKS_RST = 11'd16;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_SLICES = 2'd1,
    REG_STACKS = 2'd2
  } cfg_reg_t;

  localparam int unsigned DIV_STAGES = 17;
  localparam int unsigned SC_STAGES  = 11;
  localparam int unsigned LAT        = 1 + DIV_STAGES + SC_STAGES + 4;
  localparam int unsigned TEX_DLY    = LAT - 1 - DIV_STAGES;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;

  // reciprocals for exact truncating division of 30-bit values
  localparam logic [31:0] RCP_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] RCP_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] RCP_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [31:0] RCP_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } sc_ctl_t;

  function automatic logic [Q30_W-1:0] div_rcp(input logic [Q30_W-1:0] n,
                                                input logic [31:0] m,
                                                input int unsigned sh);
    logic [61:0] prod;
    prod = {32'd0, n} * {30'd0, m};
    return Q30_W'(prod >> sh);
  endfunction

  // q30 magnitude to q1.15 with rounding and saturation, then sign
  function automatic logic signed [NRM_W-1:0] to_q15(input logic [30:0] m, input logic neg);
    logic [16:0] r;
    logic [15:0] s;
    r = 17'((32'(m) + 32'd16384) >> 15);
    s = (r > 17'd32767) ? 16'd32767 : r[15:0];
    return neg ? -$signed(s) : $signed(s);
  endfunction

  // product scaled by 2^-15, rounded half away from zero
  function automatic logic signed [18:0] rnd15(input logic signed [33:0] p);
    logic [33:0] mag;
    logic [18:0] r;
    mag = p[33] ? 34'(-p) : 34'(p);
    r = 19'((mag + 34'd16384) >> 15);
    return p[33] ? -$signed(r) : $signed(r);
  endfunction

endpackage

>>> design/uvs_if.sv
// uvs channel interfaces: grid point input, vertex output and register writes
// depends on uvs_pkg for field widths
interface uvs_in_if;
  import uvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] stack_index;
  logic [IDX_W-1:0] slice_index;
  modport source(output valid, stack_index, slice_index, input ready);
  modport sink(input valid, stack_index, slice_index, output ready);
endinterface

interface uvs_out_if;
  import uvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;
  logic signed [NRM_W-1:0] norm_z;
  logic [FRAC_W-1:0]       tex_u;
  logic [FRAC_W-1:0]       tex_v;
  logic                    out_of_range;
  modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 tex_u, tex_v, out_of_range, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
               tex_u, tex_v, out_of_range, output ready);
endinterface

interface uvs_cfg_if;
  import uvs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/uvs_divider.sv
// uvs_divider: pipelined restoring divider, one quotient bit per stage
// depends on uvs_pkg; the user must keep the divisor static while items are in flight
module uvs_divider
  import uvs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [CNT_W-1:0]  den,
  output logic [FRAC_W-1:0] quo
);

  logic [CNT_W-1:0]  rem_r [DIV_STAGES];
  logic [FRAC_W-1:0] wrk_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [CNT_W-1:0]  rem_in;
    logic [FRAC_W-1:0] wrk_in;
    logic [CNT_W:0]    trial;
    logic              ge;
    logic [CNT_W-1:0]  rem_nxt;
    logic [FRAC_W-1:0] wrk_nxt;

    if (k == 0) begin : g_first
      // the top bits of the numerator are always below the divisor
      assign rem_in = CNT_W'(num[NUM_W-1:FRAC_W]);
      assign wrk_in = num[FRAC_W-1:0];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign wrk_in = wrk_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, wrk_in[FRAC_W-1]};
      ge      = trial >= {1'b0, den};
      rem_nxt = ge ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
      wrk_nxt = {wrk_in[FRAC_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        wrk_r[k] <= wrk_nxt;
      end
    end
  end

  assign quo = wrk_r[DIV_STAGES-1];

endmodule

>>> design/uvs_sincos.sv
// uvs_sincos: pipelined sine and cosine of a 16-bit turn phase, q1.15 results
// depends on uvs_pkg; horner series in q30 with octant folding
module uvs_sincos
  import uvs_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [PHASE_W-1:0]      phase,
  output logic signed [NRM_W-1:0] sin_q15,
  output logic signed [NRM_W-1:0] cos_q15
);

  sc_ctl_t          ctl_r [1:10];
  logic [13:0]      tp_r;
  logic [Q30_W-1:0] x_r   [2:8];
  logic [Q30_W-1:0] x2_r  [3:8];
  logic [Q30_W-1:0] ds_r  [4:8];
  logic [Q30_W-1:0] dc_r  [4:8];
  logic [30:0]      s_r   [9:10];
  logic [Q30_W-1:0] pc9_r;
  logic [30:0]      c_r;
  logic signed [NRM_W-1:0] sin_r;
  logic signed [NRM_W-1:0] cos_r;

  logic [13:0]      tp_nxt;
  logic [46:0]      xprod;
  logic [59:0]      x2prod;
  logic [60:0]      ps_prod;
  logic [60:0]      pc_prod;
  logic [60:0]      s_prod;
  logic [60:0]      c_prod;
  logic [30:0]      s0;
  logic [30:0]      c0;
  logic signed [NRM_W-1:0] sin_nxt;
  logic signed [NRM_W-1:0] cos_nxt;

  always_comb begin
    // fold the upper half of each quadrant back onto the first octant
    tp_nxt = phase[13] ? 14'(15'd16384 - {1'b0, phase[13:0]}) : phase[13:0];
    xprod  = 47'(tp_r) * 47'(HALF_PI_Q32);
    x2prod = 60'(x_r[2]) * 60'(x_r[2]);
    ps_prod = 61'(x2_r[4]) * 61'(Q30_ONE - 31'(ds_r[4]));
    pc_prod = 61'(x2_r[4]) * 61'(Q30_ONE - 31'(dc_r[4]));
    s_prod  = 61'(x_r[8]) * 61'(Q30_ONE - 31'(ds_r[8]));
    c_prod  = 61'(x2_r[8]) * 61'(Q30_ONE - 31'(dc_r[8]));

    s0 = ctl_r[10].swap ? c_r : s_r[10];
    c0 = ctl_r[10].swap ? s_r[10] : c_r;
    case (ctl_r[10].quad)
      2'd0: begin
        sin_nxt = to_q15(s0, 1'b0);
        cos_nxt = to_q15(c0, 1'b0);
      end
      2'd1: begin
        sin_nxt = to_q15(c0, 1'b0);
        cos_nxt = to_q15(s0, 1'b1);
      end
      2'd2: begin
        sin_nxt = to_q15(s0, 1'b1);
        cos_nxt = to_q15(c0, 1'b1);
      end
      default: begin
        sin_nxt = to_q15(c0, 1'b1);
        cos_nxt = to_q15(s0, 1'b0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[1] <= '{quad: phase[15:14], swap: phase[13]};
      for (int k = 2; k <= 10; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      tp_r <= tp_nxt;
      // angle in radians, q30
      x_r[2] <= Q30_W'((xprod + 47'd32768) >> 16);
      for (int k = 3; k <= 8; k++) begin
        x_r[k] <= x_r[k-1];
      end
      x2_r[3] <= Q30_W'(x2prod >> 30);
      for (int k = 4; k <= 8; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      ds_r[4] <= div_rcp(x2_r[3], RCP_42, 36);
      dc_r[4] <= div_rcp(x2_r[3], RCP_56, 36);
      ds_r[5] <= Q30_W'(ps_prod >> 30);
      dc_r[5] <= Q30_W'(pc_prod >> 30);
      ds_r[6] <= div_rcp(ds_r[5], RCP_20, 35);
      dc_r[6] <= div_rcp(dc_r[5], RCP_30, 35);
      ds_r[7] <= Q30_W'(61'(x2_r[6]) * 61'(Q30_ONE - 31'(ds_r[6])) >> 30);
      dc_r[7] <= Q30_W'(61'(x2_r[6]) * 61'(Q30_ONE - 31'(dc_r[6])) >> 30);
      ds_r[8] <= div_rcp(ds_r[7], RCP_6, 33);
      dc_r[8] <= div_rcp(dc_r[7], RCP_12, 34);
      s_r[9]  <= 31'(s_prod >> 30);
      pc9_r   <= Q30_W'(c_prod >> 30);
      s_r[10] <= s_r[9];
      c_r     <= Q30_ONE - 31'(pc9_r >> 1);
      sin_r   <= sin_nxt;
      cos_r   <= cos_nxt;
    end
  end

  assign sin_q15 = sin_r;
  assign cos_q15 = cos_r;

endmodule

>>> design/uv_sphere_vertex_generator.sv
// uv_sphere_vertex_generator: top level, one uv sphere vertex per grid point
// depends on uvs_pkg, uvs_if, uvs_divider and uvs_sincos
//
//   channel   dir  fields                                     handshake
//   in_bus    in   stack_index, slice_index                   valid/ready
//   out_bus   out  pos_x/y/z, norm_x/y/z, tex_u/v, out_of_range valid/ready
//   cfg_bus   in   index, data (radius, slice count, stack count) valid/ready
//
// one beat enters per cycle unless the output stalls; each vertex passes through
// the 17 bit-stages of the fraction dividers and the 11-stage sine/cosine unit.
// a stalled output freezes every stage at once, and in_bus.ready is low only then.
// synchronous active-low reset clears the valid line and loads the register defaults.
// cfg_bus.ready is always high.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  uvs_in_if.sink   in_bus,
  uvs_out_if.source out_bus,
  uvs_cfg_if.sink  cfg_bus
);

  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] slices_r;
  logic [CNT_W-1:0] stacks_r;

  logic             vld_r [LAT];
  logic             oor_r [LAT];
  logic [IDX_W-1:0] si_r;
  logic [IDX_W-1:0] sj_r;
  logic [FRAC_W-1:0] texu_r [TEX_DLY];
  logic [FRAC_W-1:0] texv_r [TEX_DLY];

  logic signed [33:0] pnx_r;
  logic signed [33:0] pnz_r;
  logic signed [NRM_W-1:0] ny1_r;
  logic signed [NRM_W-1:0] nx_r;
  logic signed [NRM_W-1:0] ny_r;
  logic signed [NRM_W-1:0] nz_r;
  logic signed [NRM_W-1:0] nx3_r;
  logic signed [NRM_W-1:0] ny3_r;
  logic signed [NRM_W-1:0] nz3_r;
  logic signed [33:0] ppx_r;
  logic signed [33:0] ppy_r;
  logic signed [33:0] ppz_r;
  logic signed [NRM_W-1:0] nx4_r;
  logic signed [NRM_W-1:0] ny4_r;
  logic signed [NRM_W-1:0] nz4_r;
  logic signed [POS_W-1:0] posx_r;
  logic signed [POS_W-1:0] posy_r;
  logic signed [POS_W-1:0] posz_r;

  logic             en;
  logic             in_take;
  logic [CNT_W-1:0] stacks;
  logic [CNT_W-1:0] slices;
  logic [IDX_W-1:0] si_nxt;
  logic [IDX_W-1:0] sj_nxt;
  logic             oor_nxt;
  logic [NUM_W-1:0] num_v;
  logic [NUM_W-1:0] num_u;
  logic [FRAC_W-1:0] frac_v;
  logic [FRAC_W-1:0] frac_u;
  logic [PHASE_W-1:0] polar_ph;
  logic [PHASE_W-1:0] azim_ph;
  logic signed [NRM_W-1:0] sp;
  logic signed [NRM_W-1:0] cp;
  logic signed [NRM_W-1:0] sa;
  logic signed [NRM_W-1:0] ca;
  logic signed [16:0] rad_s;

  assign en      = !vld_r[LAT-1] || out_bus.ready;
  assign in_take = in_bus.valid && en;
  assign in_bus.ready  = en;
  assign cfg_bus.ready = 1'b1;

  // zero counts act as one, large counts as the maximum
  always_comb begin
    stacks = (stacks_r == '0) ? CNT_W'(1) :
             (stacks_r > MAX_DIVISIONS) ? MAX_DIVISIONS : stacks_r;
    slices = (slices_r == '0) ? CNT_W'(1) :
             (slices_r > MAX_DIVISIONS) ? MAX_DIVISIONS : slices_r;
    si_nxt  = (in_bus.stack_index > stacks) ? stacks : in_bus.stack_index;
    sj_nxt  = (in_bus.slice_index > slices) ? slices : in_bus.slice_index;
    oor_nxt = (in_bus.stack_index > stacks) || (in_bus.slice_index > slices);
    num_v   = {si_r, 16'd0} + NUM_W'(stacks >> 1);
    num_u   = {sj_r, 16'd0} + NUM_W'(slices >> 1);
    polar_ph = PHASE_W'((18'(frac_v) + 18'd1) >> 1);
    azim_ph  = frac_u[PHASE_W-1:0];
    rad_s    = $signed({1'b0, radius_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      slices_r <= SLICES_RST;
      stacks_r <= STACKS_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_RADIUS: radius_r <= cfg_bus.data;
        REG_SLICES: slices_r <= cfg_bus.data[CNT_W-1:0];
        REG_STACKS: stacks_r <= cfg_bus.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_bus.valid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      si_r     <= si_nxt;
      sj_r     <= sj_nxt;
      oor_r[0] <= oor_nxt && in_take;
      for (int k = 1; k < LAT; k++) begin
        oor_r[k] <= oor_r[k-1];
      end
      texu_r[0] <= frac_u;
      texv_r[0] <= frac_v;
      for (int k = 1; k < TEX_DLY; k++) begin
        texu_r[k] <= texu_r[k-1];
        texv_r[k] <= texv_r[k-1];
      end
      // normal products
      pnx_r <= 34'(sp * ca);
      pnz_r <= 34'(sp * sa);
      ny1_r <= cp;
      nx_r  <= NRM_W'(rnd15(pnx_r));
      nz_r  <= NRM_W'(rnd15(pnz_r));
      ny_r  <= ny1_r;
      // position products
      ppx_r <= 34'(nx_r * rad_s);
      ppy_r <= 34'(ny_r * rad_s);
      ppz_r <= 34'(nz_r * rad_s);
      nx3_r <= nx_r;
      ny3_r <= ny_r;
      nz3_r <= nz_r;
      posx_r <= POS_W'(rnd15(ppx_r));
      posy_r <= POS_W'(rnd15(ppy_r));
      posz_r <= POS_W'(rnd15(ppz_r));
      nx4_r <= nx3_r;
      ny4_r <= ny3_r;
      nz4_r <= nz3_r;
    end
  end

  uvs_divider u_div_v (
    .clk (clk),
    .en  (en),
    .num (num_v),
    .den (stacks),
    .quo (frac_v)
  );

  uvs_divider u_div_u (
    .clk (clk),
    .en  (en),
    .num (num_u),
    .den (slices),
    .quo (frac_u)
  );

  uvs_sincos u_sc_polar (
    .clk     (clk),
    .en      (en),
    .phase   (polar_ph),
    .sin_q15 (sp),
    .cos_q15 (cp)
  );

  uvs_sincos u_sc_azim (
    .clk     (clk),
    .en      (en),
    .phase   (azim_ph),
    .sin_q15 (sa),
    .cos_q15 (ca)
  );

  assign out_bus.valid        = vld_r[LAT-1];
  assign out_bus.pos_x        = posx_r;
  assign out_bus.pos_y        = posy_r;
  assign out_bus.pos_z        = posz_r;
  assign out_bus.norm_x       = nx4_r;
  assign out_bus.norm_y       = ny4_r;
  assign out_bus.norm_z       = nz4_r;
  assign out_bus.tex_u        = texu_r[TEX_DLY-1];
  assign out_bus.tex_v        = texv_r[TEX_DLY-1];
  assign out_bus.out_of_range = oor_r[LAT-1];

endmodule

>>> dv/uv_sphere_vertex_generator_tb.sv
// testbench for uv_sphere_vertex_generator: drives grid points and register writes,
// predicts every vertex in integer arithmetic and compares each output beat
// depends on uvs_pkg, uvs_if and the design sources
module uv_sphere_vertex_generator_tb;
  import uvs_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic [FRAC_W-1:0]       tex_u;
    logic [FRAC_W-1:0]       tex_v;
    logic                    oor;
  } vertex_t;

  logic clk;
  logic rst_n;
  bit   failed;
  bit   no_idle;
  int   out_wait;

  logic [RAD_W-1:0] radius_q88;
  logic [CNT_W-1:0] slices_reg;
  logic [CNT_W-1:0] stacks_reg;

  vertex_t vertex_q[$];

  uvs_in_if  in_if();
  uvs_out_if out_if();
  uvs_cfg_if cfg_if();

  uv_sphere_vertex_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if),
    .cfg_bus(cfg_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5000000;
    $display("** uv_sphere_vertex_generator: FAILED **");
    $finish;
  end

  function automatic longint unsigned eff_divs(logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > 1024) return 1024;
    return c;
  endfunction

  // taylor sine/cosine of t (2^-32 turn units, at most an eighth turn), q30
  function automatic void taylor_q30(longint unsigned t, output longint unsigned s,
                                     output longint unsigned c);
    longint unsigned one, x, x2, a;
    one = 64'd1 << 30;
    x   = (t * 64'd6746518852 + (64'd1 << 31)) >> 32;
    x2  = (x * x) >> 30;
    a = one - x2 / 42;
    a = one - ((x2 * a) >> 30) / 20;
    a = one - ((x2 * a) >> 30) / 6;
    s = (x * a) >> 30;
    a = one - x2 / 56;
    a = one - ((x2 * a) >> 30) / 30;
    a = one - ((x2 * a) >> 30) / 12;
    c = one - ((x2 * a) >> 30) / 2;
  endfunction

  function automatic int mag_to_q15(longint unsigned m, bit neg);
    longint unsigned r;
    r = (m + 16384) >> 15;
    if (r > 32767) r = 32767;
    return neg ? -int'(r) : int'(r);
  endfunction

  function automatic void turn_sincos(logic [31:0] turn, output int sn, output int cs);
    longint unsigned r, s0, c0;
    r = turn[29:0];
    if (r < (64'd1 << 29)) taylor_q30(r, s0, c0);
    else taylor_q30((64'd1 << 30) - r, c0, s0);
    case (turn[31:30])
      2'd0: begin sn = mag_to_q15(s0, 0); cs = mag_to_q15(c0, 0); end
      2'd1: begin sn = mag_to_q15(c0, 0); cs = mag_to_q15(s0, 1); end
      2'd2: begin sn = mag_to_q15(s0, 1); cs = mag_to_q15(c0, 1); end
      default: begin sn = mag_to_q15(c0, 1); cs = mag_to_q15(s0, 0); end
    endcase
  endfunction

  function automatic int mul_round15(int a, int b);
    longint ma, mb, m;
    ma = (a < 0) ? -longint'(a) : longint'(a);
    mb = (b < 0) ? -longint'(b) : longint'(b);
    m  = (ma * mb + 16384) >>> 15;
    return ((a < 0) != (b < 0)) ? -int'(m) : int'(m);
  endfunction

  function automatic vertex_t predict_vertex(logic [IDX_W-1:0] stk, logic [IDX_W-1:0] slc);
    vertex_t vx;
    longint unsigned stacks, slices, si, sj, v, u, pp, pa;
    int sp, cp, sa, ca, nx, nz;
    stacks = eff_divs(stacks_reg);
    slices = eff_divs(slices_reg);
    si = stk;
    sj = slc;
    vx.oor = 0;
    if (si > stacks) begin si = stacks; vx.oor = 1; end
    if (sj > slices) begin sj = slices; vx.oor = 1; end
    v  = (si * 65536 + stacks / 2) / stacks;
    u  = (sj * 65536 + slices / 2) / slices;
    pp = ((v << 15) + 32768) >> 16;
    pa = (((u << 16) + 32768) >> 16) & 64'hFFFF;
    turn_sincos(32'(pp << 16), sp, cp);
    turn_sincos(32'(pa << 16), sa, ca);
    nx = mul_round15(sp, ca);
    nz = mul_round15(sp, sa);
    vx.norm_x = nx[NRM_W-1:0];
    vx.norm_y = cp[NRM_W-1:0];
    vx.norm_z = nz[NRM_W-1:0];
    vx.pos_x  = POS_W'(mul_round15(nx, int'(radius_q88)));
    vx.pos_y  = POS_W'(mul_round15(cp, int'(radius_q88)));
    vx.pos_z  = POS_W'(mul_round15(nz, int'(radius_q88)));
    vx.tex_u  = FRAC_W'(u);
    vx.tex_v  = FRAC_W'(v);
    return vx;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t vertex %s mismatch: expected %0d actual %0d", $time, name, e, a);
      failed = 1;
    end
  endtask

  // result side: random stalls unless no_idle is set, compare each beat with the oldest prediction
  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t vertex beat with nothing expected", $time);
          failed = 1;
        end else begin
          e = vertex_q.pop_front();
          check_field("pos_x", e.pos_x, out_if.pos_x);
          check_field("pos_y", e.pos_y, out_if.pos_y);
          check_field("pos_z", e.pos_z, out_if.pos_z);
          check_field("norm_x", e.norm_x, out_if.norm_x);
          check_field("norm_y", e.norm_y, out_if.norm_y);
          check_field("norm_z", e.norm_z, out_if.norm_z);
          check_field("tex_u", e.tex_u, out_if.tex_u);
          check_field("tex_v", e.tex_v, out_if.tex_v);
          check_field("out_of_range", e.oor, out_if.out_of_range);
        end
        out_wait = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_point(logic [IDX_W-1:0] stk, logic [IDX_W-1:0] slc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stack_index <= stk;
    in_if.slice_index <= slc;
    do @(posedge clk); while (!in_if.ready);
    vertex_q.insert(vertex_q.size(), predict_vertex(stk, slc));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_RADIUS: radius_q88 = val;
      REG_SLICES: slices_reg = val[CNT_W-1:0];
      REG_STACKS: stacks_reg = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] sl,
                            logic [CFG_DATA_W-1:0] st);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_SLICES, sl);
    write_reg(REG_STACKS, st);
    cfg_if.valid <= 1'b0;
  endtask

  // poles, seam, equator, clamping at the default sphere
  task automatic test_default_grid();
    send_point(0, 0);
    send_point(16, 32);
    send_point(8, 0);
    send_point(8, 8);
    send_point(8, 16);
    send_point(4, 24);
    send_point(1, 1);
    send_point(15, 31);
    send_point(17, 0);
    send_point(0, 33);
    send_point(11'h7FF, 11'h7FF);
    send_point(11'h555, 11'h2AA);
    send_point(11'h2AA, 11'h555);
  endtask

  // extreme radius and counts, including zero and oversize counts
  task automatic test_config_extremes();
    set_sphere(16'hFFFF, 1024, 1024);
    send_point(512, 256);
    send_point(1024, 1024);
    send_point(341, 128);
    send_point(1025, 1023);
    set_sphere(0, 0, 0);
    send_point(0, 1);
    send_point(1, 0);
    send_point(2, 2);
    set_sphere(16'h0100, 2047, 2047);
    send_point(700, 900);
    send_point(2047, 1024);
    set_sphere(16'h7FFF, 1, 1);
    send_point(1, 1);
    send_point(0, 1);
  endtask

  function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] c);
    int unsigned n, k;
    n = 32'(eff_divs(c));
    k = $urandom_range(0, 19);
    if (k < 15) return IDX_W'($urandom_range(0, n));
    if (k < 17) return IDX_W'($urandom_range(0, 2047));
    if (k < 18) return 0;
    return IDX_W'(n);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k == 1) return 1024;
    if (k == 2) return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    if (k < 6) return CFG_DATA_W'($urandom_range(1, 64));
    return CFG_DATA_W'($urandom_range(1, 1024));
  endfunction

  task automatic test_random_grid();
    for (int ph = 0; ph < 8; ph++) begin
      set_sphere(CFG_DATA_W'($urandom_range(0, 16'hFFFF)), pick_count(), pick_count());
      no_idle = (ph % 3 == 1);
      for (int i = 0; i < 200; i++) send_point(pick_index(stacks_reg), pick_index(slices_reg));
    end
    no_idle = 0;
  endtask

  initial begin
    failed = 0;
    no_idle = 0;
    radius_q88 = RADIUS_RST;
    slices_reg = SLICES_RST;
    stacks_reg = STACKS_RST;
    rst_n = 1'b0;
    in_if.valid <= 1'b0;
    in_if.stack_index <= '0;
    in_if.slice_index <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_RADIUS;
    cfg_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_grid();
    test_config_extremes();
    test_random_grid();
    drain();
    repeat (40) @(posedge clk);
    if (!failed && vertex_q.size() == 0) begin
      $display("** uv_sphere_vertex_generator: PASSED **");
    end else begin
      $display("** uv_sphere_vertex_generator: FAILED **");
    end
    $finish;
  end

endmodule

>>> uv_sphere_vertex_generator.f
design/uvs_pkg.sv
design/uvs_if.sv
design/uvs_divider.sv
design/uvs_sincos.sv
design/uv_sphere_vertex_generator.sv
dv/uv_sphere_vertex_generator_tb.sv
